// ===== hdl/icmr_pkg.sv =====
// ---------------------------------------------------------------------------
// icmr_pkg
// Shared types and constants for the int8 convolution MAC and requantize engine.
// ---------------------------------------------------------------------------
`default_nettype none

package icmr_pkg;

    localparam int QueueDepth = 2;
    localparam int SumW       = 48;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 8;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CFG_IN_OFF   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_WGT_OFF  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_RES_OFF  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CLAMP_LO = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CLAMP_HI = 3'd4;

    localparam logic signed [31:0] Int32Min = 32'sh8000_0000;
    localparam logic signed [31:0] Int32Max = 32'sh7fff_ffff;
    localparam logic signed [63:0] NudgePos = 64'sd1073741824;
    localparam logic signed [63:0] NudgeNeg = -64'sd1073741823;
    localparam logic signed [63:0] TruncFix = 64'sd2147483647;

    typedef struct packed {
        logic signed [7:0] in_off;
        logic signed [7:0] wgt_off;
        logic signed [7:0] res_off;
        logic signed [7:0] clamp_lo;
        logic signed [7:0] clamp_hi;
    } cfg_t;

    // one finished sum waiting for requantization
    typedef struct packed {
        logic signed [SumW-1:0] sum;
        logic signed [31:0]     mult;
        logic signed [5:0]      shift;
    } job_t;

endpackage

`default_nettype wire

// ===== hdl/icmr_if.sv =====
// ---------------------------------------------------------------------------
// icmr_if
// Valid/ready channels: operand terms in, requantized samples out.
// ---------------------------------------------------------------------------
`default_nettype none

interface icmr_term_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  act_value;
    logic signed [7:0]  wgt_value;
    logic               tap_valid;
    logic               first_term;
    logic signed [31:0] bias_value;
    logic               last_term;
    logic signed [31:0] scale_multiplier;
    logic signed [5:0]  scale_shift;

    modport source (
        output valid, act_value, wgt_value, tap_valid, first_term, bias_value,
               last_term, scale_multiplier, scale_shift,
        input  ready
    );
    modport sink (
        input  valid, act_value, wgt_value, tap_valid, first_term, bias_value,
               last_term, scale_multiplier, scale_shift,
        output ready
    );
endinterface

interface icmr_result_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] out_value;

    modport source (output valid, out_value, input ready);
    modport sink (input valid, out_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/int8_conv_mac_requantize.sv =====
// A last term's sum goes through the sum queue into the requantizer's job register
// and then its saturate to output states; terms are taken one per cycle while the
// sum queue has room, and the requantizer takes no new sum until its result is written.
// The queue holds QUEUE_DEPTH finished sums between accumulator and scaler.
// Reset clears the running sum, queue and control; clamp resets to -128..127,
// zero points to 0.
// ---------------------------------------------------------------------------
// int8_conv_mac_requantize
// Top level: configuration registers, accumulator front, sum queue and
// requantizing back end.
// ---------------------------------------------------------------------------
`default_nettype none

module int8_conv_mac_requantize #(
    parameter int QUEUE_DEPTH = icmr_pkg::QueueDepth
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    icmr_term_if.sink                          term,
    icmr_result_if.source                      result,
    input  wire logic                          cfg_we,
    input  wire logic [icmr_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [icmr_pkg::CfgDataW-1:0] cfg_wdata
);
    import icmr_pkg::*;

    cfg_t cfg_reg;
    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t back_job;
    logic back_valid;
    logic back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_off   <= 8'sd0;
            cfg_reg.wgt_off  <= 8'sd0;
            cfg_reg.res_off  <= 8'sd0;
            cfg_reg.clamp_lo <= -8'sd128;
            cfg_reg.clamp_hi <= 8'sd127;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IN_OFF:   cfg_reg.in_off   <= cfg_wdata;
                CFG_WGT_OFF:  cfg_reg.wgt_off  <= cfg_wdata;
                CFG_RES_OFF:  cfg_reg.res_off  <= cfg_wdata;
                CFG_CLAMP_LO: cfg_reg.clamp_lo <= cfg_wdata;
                CFG_CLAMP_HI: cfg_reg.clamp_hi <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    icmr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .term      (term),
        .cfg       (cfg_reg),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    icmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_data  (front_job),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_data   (back_job),
        .pop_ready  (back_ready)
    );

    icmr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .cfg       (cfg_reg),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== hdl/icmr_front.sv =====
// ---------------------------------------------------------------------------
// icmr_front
// Takes one term a cycle while the queue has room, removes zero points and accumulates the product;
// a last term hands the finished sum to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module icmr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    icmr_term_if.sink          term,
    input  wire icmr_pkg::cfg_t cfg,
    output icmr_pkg::job_t     job,
    output logic               job_valid,
    input  wire logic          job_ready
);
    import icmr_pkg::*;

    logic signed [8:0]      act_d;
    logic signed [8:0]      wgt_d;
    logic signed [17:0]     prod;
    logic signed [SumW-1:0] base;
    logic signed [SumW-1:0] sum_next;
    logic signed [SumW-1:0] sum_reg;
    logic                   accept;

    // terms are held back only when the queue has no room
    assign term.ready = job_ready;
    assign accept     = term.valid & job_ready;

    assign act_d = {term.act_value[7], term.act_value} - {cfg.in_off[7], cfg.in_off};
    assign wgt_d = {term.wgt_value[7], term.wgt_value} - {cfg.wgt_off[7], cfg.wgt_off};
    assign prod  = 18'(act_d) * 18'(wgt_d);

    assign base = term.first_term ?
                  {{(SumW-32){term.bias_value[31]}}, term.bias_value} : sum_reg;
    assign sum_next = base +
                      (term.tap_valid ? {{(SumW-18){prod[17]}}, prod} : {SumW{1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (accept)
        begin
            sum_reg <= sum_next;
        end
    end

    assign job.sum   = sum_next;
    assign job.mult  = term.scale_multiplier;
    assign job.shift = term.scale_shift;
    assign job_valid = accept & term.last_term;

endmodule

`default_nettype wire

// ===== hdl/icmr_queue.sv =====
// ---------------------------------------------------------------------------
// icmr_queue
// Short FIFO of finished sums between the accumulator and the requantizer.
// ---------------------------------------------------------------------------
`default_nettype none

module icmr_queue #(
    parameter int DEPTH = icmr_pkg::QueueDepth
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire icmr_pkg::job_t push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output icmr_pkg::job_t      pop_data,
    input  wire logic           pop_ready
);
    import icmr_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    job_t            entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push & push_ready;
    assign pop_fire   = pop_valid & pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + CntW'(1);
            2'b01:   count_next = count_reg - CntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("sum pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/icmr_back.sv =====
// ---------------------------------------------------------------------------
// icmr_back
// Requantizer: saturate, left shift, doubling high multiply, rounding right
// shift, output offset and clamp, one step a cycle for one sum at a time; the
// output step waits while the previous result is not yet taken.
`default_nettype none

module icmr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire icmr_pkg::job_t job,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire icmr_pkg::cfg_t cfg,
    icmr_result_if.source       result
);
    import icmr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SAT  = 3'd1;
    localparam logic [2:0] ST_SHL  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_NDG  = 3'd4;
    localparam logic [2:0] ST_DH   = 3'd5;
    localparam logic [2:0] ST_RND  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    job_t               job_reg;
    logic signed [31:0] v_reg;
    logic signed [63:0] prod_reg;
    logic               both_min_reg;
    logic signed [31:0] dh_reg;
    logic signed [31:0] rnd_reg;
    logic signed [7:0]  out_reg;
    logic               out_valid_reg;

    logic signed [5:0]  sh;
    logic [5:0]         sh_neg;
    logic [4:0]         left_amt;
    logic [4:0]         right_amt;
    logic               sum_fits;
    logic [62:0]        shl;
    logic               shl_fits;
    logic signed [63:0] trunc;
    logic [31:0]        mask;
    logic [31:0]        rem;
    logic [31:0]        thr;
    logic signed [31:0] q;
    logic signed [33:0] val;
    logic signed [33:0] val_hi;
    logic signed [33:0] lo_ext;
    logic signed [33:0] hi_ext;
    logic               out_write;

    assign job_ready = (state_reg == ST_IDLE);

    // shift -32 behaves as -31, 31 as 30
    always_comb
    begin
        sh = job_reg.shift;
        if (job_reg.shift == -6'sd32)
        begin
            sh = -6'sd31;
        end
        else if (job_reg.shift == 6'sd31)
        begin
            sh = 6'sd30;
        end
    end

    assign sh_neg    = -sh;
    assign left_amt  = (sh > 6'sd0) ? sh[4:0] : 5'd0;
    assign right_amt = (sh < 6'sd0) ? sh_neg[4:0] : 5'd0;

    assign sum_fits = (&job_reg.sum[SumW-1:31]) | ~(|job_reg.sum[SumW-1:31]);
    assign shl      = {{31{v_reg[31]}}, v_reg} << left_amt;
    assign shl_fits = (&shl[62:31]) | ~(|shl[62:31]);

    // division by 2^31 truncates towards zero
    assign trunc = prod_reg[63] ? prod_reg + TruncFix : prod_reg;

    assign mask = (32'd1 << right_amt) - 32'd1;
    assign rem  = dh_reg & mask;
    assign thr  = (mask >> 1) + {31'd0, dh_reg[31]};
    assign q    = dh_reg >>> right_amt;

    assign lo_ext = {{26{cfg.clamp_lo[7]}}, cfg.clamp_lo};
    assign hi_ext = {{26{cfg.clamp_hi[7]}}, cfg.clamp_hi};
    assign val    = {{2{rnd_reg[31]}}, rnd_reg} + {{26{cfg.res_off[7]}}, cfg.res_off};
    assign val_hi = (val > hi_ext) ? hi_ext : val;

    assign out_write = (state_reg == ST_OUT) & (~out_valid_reg | result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_SAT;
            ST_SAT:  state_next = ST_SHL;
            ST_SHL:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_NDG;
            ST_NDG:  state_next = ST_DH;
            ST_DH:   state_next = ST_RND;
            ST_RND:  state_next = ST_OUT;
            ST_OUT:  if (out_write) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && state_reg == ST_IDLE)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_SAT)
        begin
            v_reg <= sum_fits ? job_reg.sum[31:0] :
                     (job_reg.sum[SumW-1] ? Int32Min : Int32Max);
        end
        if (state_reg == ST_SHL)
        begin
            v_reg <= shl_fits ? shl[31:0] : (shl[62] ? Int32Min : Int32Max);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg     <= 64'(v_reg) * 64'(job_reg.mult);
            both_min_reg <= (v_reg == Int32Min) && (job_reg.mult == Int32Min);
        end
        if (state_reg == ST_NDG)
        begin
            prod_reg <= prod_reg + (prod_reg[63] ? NudgeNeg : NudgePos);
        end
        if (state_reg == ST_DH)
        begin
            dh_reg <= both_min_reg ? Int32Max : trunc[62:31];
        end
        if (state_reg == ST_RND)
        begin
            rnd_reg <= q + ((rem > thr) ? 32'sd1 : 32'sd0);
        end
        if (out_write)
        begin
            out_reg <= (val_hi < lo_ext) ? cfg.clamp_lo : val_hi[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_value = out_reg;

`ifndef SYNTHESIS
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |=> (state_reg == ST_SAT))
        else $error("taken sum did not start requantization");

    a_word_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result word appeared outside the output step");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Drives int8 activation/weight words into the conv MAC and requantize engine
// and checks every output sample against a behavioural predictor of the sum,
// scaling, zero point and clamp, across several register settings and idle
// patterns.
// ---------------------------------------------------------------------------
module tb;

    import icmr_pkg::*;

    localparam int HoldCycles = 300;
    localparam int DrainLimit = 20000;
    localparam int PhaseItems = 190;

    typedef struct {
        logic signed [7:0]  act_value;
        logic signed [7:0]  wgt_value;
        logic               tap_valid;
        logic               first_term;
        logic signed [31:0] bias_value;
        logic               last_term;
        logic signed [31:0] scale_multiplier;
        logic signed [5:0]  scale_shift;
    } term_word_t;

    // running sum and register shadow; queues the int8 samples still owed
    class requant_scoreboard;
        logic signed [47:0] running_sum;
        cfg_t               cfg;
        logic [7:0]         owed_samples[$];
        int                 mismatch_count;

        function new();
            running_sum    = '0;
            cfg.in_off     = 8'sd0;
            cfg.wgt_off    = 8'sd0;
            cfg.res_off    = 8'sd0;
            cfg.clamp_lo   = -8'sd128;
            cfg.clamp_hi   = 8'sd127;
            mismatch_count = 0;
        endfunction

        function int pending();
            return owed_samples.size();
        endfunction

        function longint saturate32(longint v);
            if (v < longint'(Int32Min))
                return longint'(Int32Min);
            if (v > longint'(Int32Max))
                return longint'(Int32Max);
            return v;
        endfunction

        function logic [7:0] requantize_sum(logic signed [47:0] total,
                                            logic signed [31:0] mult,
                                            logic signed [5:0] shift_in);
            longint             v;
            longint             p;
            longint             hi_mul;
            longint             mask;
            longint             rem;
            longint             thr;
            int                 sh;
            int                 left;
            int                 right;
            logic signed [31:0] x;
            v  = saturate32(longint'(total));
            sh = int'(shift_in);
            if (sh < -31)
                sh = -31;
            if (sh > 30)
                sh = 30;
            left  = (sh > 0) ? sh : 0;
            right = (sh < 0) ? -sh : 0;
            v = saturate32(v <<< left);
            if (v == longint'(Int32Min) && mult == Int32Min)
                hi_mul = longint'(Int32Max);
            else
            begin
                p = v * longint'(mult);
                // division truncates towards zero, hence the signed nudge
                hi_mul = (p + ((p >= 0) ? NudgePos : NudgeNeg)) / 64'sd2147483648;
            end
            x    = hi_mul[31:0];
            mask = (64'sd1 <<< right) - 64'sd1;
            rem  = longint'(x) & mask;
            thr  = (mask >>> 1) + ((x < 0) ? 64'sd1 : 64'sd0);
            v    = longint'(x >>> right) + ((rem > thr) ? 64'sd1 : 64'sd0);
            v    = v + longint'(cfg.res_off);
            if (v > longint'(cfg.clamp_hi))
                v = longint'(cfg.clamp_hi);
            if (v < longint'(cfg.clamp_lo))
                v = longint'(cfg.clamp_lo);
            return v[7:0];
        endfunction

        function void note_term(term_word_t w);
            logic signed [47:0] total;
            int                 a;
            int                 b;
            int                 prod;
            total = w.first_term ? {{16{w.bias_value[31]}}, w.bias_value} : running_sum;
            if (w.tap_valid)
            begin
                a     = int'(w.act_value) - int'(cfg.in_off);
                b     = int'(w.wgt_value) - int'(cfg.wgt_off);
                prod  = a * b;
                total = total + 48'(prod);
            end
            running_sum = total;
            if (w.last_term)
                owed_samples.push_back(requantize_sum(total, w.scale_multiplier,
                                                      w.scale_shift));
        endfunction

        function void check_sample(logic [7:0] got);
            logic [7:0] want;
            if (owed_samples.size() == 0)
            begin
                $error("out_value: expected none, actual %0d", $signed(got));
                mismatch_count++;
                return;
            end
            want = owed_samples.pop_front();
            if (got !== want)
            begin
                $error("out_value: expected %0d, actual %0d", $signed(want), $signed(got));
                mismatch_count++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;

    icmr_term_if   term_ch();
    icmr_result_if result_ch();

    requant_scoreboard sb = new();

    int src_idle_pct;
    int sink_idle_pct;
    int hold_asked;
    int hold_done;
    int offered;

    int8_conv_mac_requantize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .term      (term_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #3200000;
        $display("tb failed");
        $finish;
    end

    always @(posedge clk)
    begin : watch_channels
        term_word_t seen;
        if (rst_n)
        begin
            if (term_ch.valid && term_ch.ready)
            begin
                seen.act_value        = term_ch.act_value;
                seen.wgt_value        = term_ch.wgt_value;
                seen.tap_valid        = term_ch.tap_valid;
                seen.first_term       = term_ch.first_term;
                seen.bias_value       = term_ch.bias_value;
                seen.last_term        = term_ch.last_term;
                seen.scale_multiplier = term_ch.scale_multiplier;
                seen.scale_shift      = term_ch.scale_shift;
                sb.note_term(seen);
            end
            if (result_ch.valid && result_ch.ready)
                sb.check_sample(result_ch.out_value);
        end
    end

    // sample sink; a requested hold-off keeps ready low for a long stretch
    initial
    begin : sample_sink
        int n;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_done)
            begin
                result_ch.ready <= 1'b0;
                for (n = 0; n < HoldCycles; n++)
                    @(posedge clk);
                hold_done++;
            end
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic term_word_t term_of(int act, int wgt, bit tap, bit first, int bias,
                                           bit last, int mult, int shift);
        term_word_t w;
        w.act_value        = act[7:0];
        w.wgt_value        = wgt[7:0];
        w.tap_valid        = tap;
        w.first_term       = first;
        w.bias_value       = bias;
        w.last_term        = last;
        w.scale_multiplier = mult;
        w.scale_shift      = shift[5:0];
        return w;
    endfunction

    function automatic term_word_t random_term(bit first, bit last);
        term_word_t w;
        w.act_value  = 8'($urandom);
        w.wgt_value  = 8'($urandom);
        w.tap_valid  = ($urandom_range(9) != 0);
        w.first_term = first;
        w.last_term  = last;
        if ($urandom_range(3) == 0)
            w.bias_value = $urandom;
        else
            w.bias_value = $urandom_range(131071) - 65536;
        if ($urandom_range(3) == 0)
            w.scale_multiplier = $urandom;
        else
            w.scale_multiplier = $urandom_range(32'h7fff_ffff, 32'h2000_0000);
        if ($urandom_range(3) == 0)
            w.scale_shift = 6'($urandom);
        else
            w.scale_shift = 6'($urandom_range(20) - 16);
        return w;
    endfunction

    function automatic cfg_t mk_settings(int i, int w, int r, int lo, int hi);
        cfg_t s;
        s.in_off   = i[7:0];
        s.wgt_off  = w[7:0];
        s.res_off  = r[7:0];
        s.clamp_lo = lo[7:0];
        s.clamp_hi = hi[7:0];
        return s;
    endfunction

    function automatic cfg_t random_settings();
        return mk_settings($urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        put_reg(CFG_IN_OFF, s.in_off);
        put_reg(CFG_WGT_OFF, s.wgt_off);
        put_reg(CFG_RES_OFF, s.res_off);
        put_reg(CFG_CLAMP_LO, s.clamp_lo);
        put_reg(CFG_CLAMP_HI, s.clamp_hi);
        cfg_we  <= 1'b0;
        sb.cfg   = s;
    endtask

    task automatic offer_term(input term_word_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            term_ch.valid <= 1'b0;
            @(posedge clk);
        end
        term_ch.valid            <= 1'b1;
        term_ch.act_value        <= w.act_value;
        term_ch.wgt_value        <= w.wgt_value;
        term_ch.tap_valid        <= w.tap_valid;
        term_ch.first_term       <= w.first_term;
        term_ch.bias_value       <= w.bias_value;
        term_ch.last_term        <= w.last_term;
        term_ch.scale_multiplier <= w.scale_multiplier;
        term_ch.scale_shift      <= w.scale_shift;
        @(posedge clk);
        while (!term_ch.ready)
            @(posedge clk);
        offered++;
    endtask

    // sender stops until every owed sample is back, then lets the pipe empty
    task automatic settle();
        int waited;
        waited = 0;
        term_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic send_random_sum();
        int  len;
        bit  noisy;
        term_word_t w;
        len   = ($urandom_range(4) == 0) ? 1 : $urandom_range(16, 2);
        noisy = ($urandom_range(7) == 0);
        for (int k = 0; k < len; k++)
        begin
            if (noisy)
                w = random_term($urandom_range(1), $urandom_range(3) == 0);
            else
                w = random_term(k == 0, k == len - 1);
            offer_term(w);
        end
    endtask

    initial
    begin : stimulus
        cfg_t phase_cfg [6];
        int   target;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_wdata                = '0;
        term_ch.valid            = 1'b0;
        term_ch.act_value        = '0;
        term_ch.wgt_value        = '0;
        term_ch.tap_valid        = 1'b0;
        term_ch.first_term       = 1'b0;
        term_ch.bias_value       = '0;
        term_ch.last_term        = 1'b0;
        term_ch.scale_multiplier = '0;
        term_ch.scale_shift      = '0;
        src_idle_pct             = 0;
        sink_idle_pct            = 0;
        hold_asked               = 0;
        hold_done                = 0;
        offered                  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values; sum without a seed starts from zero
        offer_term(term_of(5, -3, 1, 0, 0, 1, 32'h4000_0000, 1));
        offer_term(term_of(127, 127, 1, 1, 0, 1, Int32Max, 0));
        offer_term(term_of(-128, -128, 1, 1, 0, 1, 32'h4000_0000, -8));
        offer_term(term_of(0, 0, 0, 1, Int32Max, 1, Int32Max, 30));
        offer_term(term_of(0, 0, 0, 1, Int32Min, 1, Int32Min, 0));
        offer_term(term_of(-128, 127, 1, 1, Int32Min, 1, Int32Max, -32));
        offer_term(term_of(127, -128, 1, 1, Int32Max, 1, 32'h7fff_0000, 31));
        offer_term(term_of(100, -100, 1, 1, -3, 1, 32'h4000_0000, -31));
        offer_term(term_of(10, 20, 1, 1, -1000, 0, 0, 0));
        offer_term(term_of(-7, 9, 1, 0, 55, 0, 0, 0));
        offer_term(term_of(90, 90, 0, 0, 0, 0, 0, 0));
        offer_term(term_of(33, -44, 1, 0, 0, 1, 32'h5a00_0000, -3));
        // carries on from the sum just emitted
        offer_term(term_of(2, 2, 1, 0, 0, 1, 32'h4000_0000, -1));
        offer_term(term_of(1, 1, 1, 1, -1, 1, -1, 0));
        settle();

        // widest zero-point differences
        load_settings(mk_settings(-128, 127, 127, -128, 127));
        offer_term(term_of(127, -128, 1, 1, 0, 1, Int32Max, -4));
        offer_term(term_of(-128, 127, 1, 1, 0, 1, Int32Max, -16));
        offer_term(term_of(127, -128, 1, 1, 0, 1, 32'h4000_0000, -31));
        settle();
        load_settings(mk_settings(127, -128, -128, -128, 127));
        offer_term(term_of(-128, 127, 1, 1, 0, 1, Int32Max, -8));
        offer_term(term_of(127, 127, 1, 1, 77, 1, Int32Max, 2));
        settle();

        // crossed clamp bounds
        load_settings(mk_settings(3, -7, 10, 50, -50));
        offer_term(term_of(40, 40, 1, 1, 0, 1, Int32Max, 0));
        offer_term(term_of(-40, 40, 1, 1, 0, 1, Int32Max, 0));
        settle();

        phase_cfg[0] = mk_settings(127, -128, -128, -5, 20);
        phase_cfg[1] = random_settings();
        phase_cfg[2] = mk_settings(-128, 127, 127, -128, 127);
        phase_cfg[3] = mk_settings(3, -7, 10, 50, -50);
        phase_cfg[4] = random_settings();
        phase_cfg[5] = mk_settings(0, 0, 0, -128, 127);
        target = offered;
        for (int ph = 0; ph < 6; ph++)
        begin
            load_settings(phase_cfg[ph]);
            src_idle_pct  = (ph < 2) ? 37 : (ph < 4) ? 83 : 0;
            sink_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 37 : 0;
            if (ph >= 4)
                hold_asked++;
            target += PhaseItems;
            while (offered < target)
                send_random_sum();
            // close any sum left open by a noisy sequence
            offer_term(random_term(1'b0, 1'b1));
            settle();
        end

        if (sb.pending() != 0)
        begin
            $error("out_value: expected %0d more samples, actual none", sb.pending());
            sb.mismatch_count++;
        end
        if (sb.mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/icmr_pkg.sv
hdl/icmr_if.sv
hdl/icmr_front.sv
hdl/icmr_queue.sv
hdl/icmr_back.sv
hdl/int8_conv_mac_requantize.sv
tb/tb.sv
